[hdl/unicode_transcoder_defines.svh]
//------------------------------------------------------------------------------
// Unicode transcoder assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is asserted.
//------------------------------------------------------------------------------
`ifndef UNICODE_TRANSCODER_DEFINES_SVH
`define UNICODE_TRANSCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/uct_pkg.sv]
//------------------------------------------------------------------------------
// Unicode transcoder package
// Encoding codes, code point constants, the decoder result type and the
// helper functions shared by the decoder and the emitter.
//------------------------------------------------------------------------------
package uct_pkg;

    typedef enum logic [1:0] {
        FMT_UTF8  = 2'd0,
        FMT_UTF16 = 2'd1,
        FMT_UTF32 = 2'd2
    } fmt_t;

    localparam logic [20:0] REPL_CP    = 21'h00FFFD;
    localparam logic [31:0] CP_MAX     = 32'h0010FFFF;
    localparam logic [31:0] SURR_FIRST = 32'h0000D800;
    localparam logic [31:0] SURR_LAST  = 32'h0000DFFF;
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] PLANE1     = 21'h010000;
    localparam logic [20:0] TWO_BYTE   = 21'h000080;
    localparam logic [20:0] THREE_BYTE = 21'h000800;

    // Up to two code points leave the decoder for one source unit: a
    // replacement for a broken open sequence, then the unit's own result.
    typedef struct packed {
        logic [20:0] cp0;
        logic [20:0] cp1;
        logic [1:0]  ncp;
    } dec_out_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic cp_invalid(input logic [31:0] cp);
        return ((cp >= SURR_FIRST) && (cp <= SURR_LAST)) || (cp > CP_MAX);
    endfunction

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < TWO_BYTE)
            n = 3'd1;
        else if (cp < THREE_BYTE)
            n = 3'd2;
        else if (cp < PLANE1)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

endpackage

[hdl/uct_decoder.sv]
//------------------------------------------------------------------------------
// Unicode transcoder decoder
// Holds the open UTF-8 sequence or pending high surrogate and turns one source
// unit into zero, one or two code points.
//------------------------------------------------------------------------------
`include "unicode_transcoder_defines.svh"

module uct_decoder
    import uct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        src_clear,
    input  fmt_t        src_fmt,
    input  logic        swap,
    input  logic [31:0] unit,
    input  logic        last,
    output dec_out_t    dec
);

    logic [20:0] acc_reg, acc_next;
    logic [2:0]  exp_reg, exp_next;
    logic [2:0]  rec_reg, rec_next;
    logic [9:0]  hs_reg, hs_next;
    logic        pend_reg, pend_next;

    logic [7:0]  b;
    logic [15:0] u;
    logic [31:0] w;
    logic [20:0] acc_shift;
    logic [2:0]  rec_inc;
    logic        pre;
    logic        main_v;
    logic [20:0] main_cp;
    logic        do_lead;
    logic        fresh;

    assign b         = unit[7:0];
    assign u         = swap ? swap16(unit[15:0]) : unit[15:0];
    assign w         = swap ? swap32(unit) : unit;
    assign acc_shift = {acc_reg[14:0], b[5:0]};
    assign rec_inc   = rec_reg + 3'd1;

    always_comb
    begin
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        rec_next  = rec_reg;
        hs_next   = hs_reg;
        pend_next = pend_reg;
        pre       = 1'b0;
        main_v    = 1'b0;
        main_cp   = '0;
        do_lead   = 1'b0;
        fresh     = 1'b0;

        case (src_fmt)
            FMT_UTF8:
            begin
                if (exp_reg != 3'd0)
                begin
                    if (b[7:6] == 2'b10)
                    begin
                        if (rec_inc >= exp_reg)
                        begin
                            // Sequence complete: reject overlong forms,
                            // surrogates and values beyond the code space.
                            main_v = 1'b1;
                            if (cp_invalid({11'd0, acc_shift}) ||
                                (utf8_len(acc_shift) != exp_reg))
                                main_cp = REPL_CP;
                            else
                                main_cp = acc_shift;
                            acc_next = '0;
                            exp_next = '0;
                            rec_next = '0;
                        end
                        else if (last)
                        begin
                            main_v  = 1'b1;
                            main_cp = REPL_CP;
                        end
                        else
                        begin
                            acc_next = acc_shift;
                            rec_next = rec_inc;
                        end
                    end
                    else
                    begin
                        // The open sequence is broken; the byte starts afresh.
                        pre      = 1'b1;
                        acc_next = '0;
                        exp_next = '0;
                        rec_next = '0;
                        do_lead  = 1'b1;
                    end
                end
                else
                begin
                    do_lead = 1'b1;
                end

                if (do_lead)
                begin
                    if (!b[7])
                    begin
                        main_v  = 1'b1;
                        main_cp = {13'd0, b};
                    end
                    else if ((b[7:6] == 2'b10) || (b[7:3] == 5'b11111))
                    begin
                        main_v  = 1'b1;
                        main_cp = REPL_CP;
                    end
                    else
                    begin
                        if (!b[5])
                        begin
                            acc_next = {16'd0, b[4:0]};
                            exp_next = 3'd2;
                        end
                        else if (!b[4])
                        begin
                            acc_next = {17'd0, b[3:0]};
                            exp_next = 3'd3;
                        end
                        else
                        begin
                            acc_next = {18'd0, b[2:0]};
                            exp_next = 3'd4;
                        end
                        rec_next = 3'd1;
                        if (last)
                        begin
                            main_v  = 1'b1;
                            main_cp = REPL_CP;
                        end
                    end
                end
            end

            FMT_UTF16:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    hs_next   = '0;
                    if ((u >= LOW_FIRST) && (u <= LOW_LAST))
                    begin
                        main_v  = 1'b1;
                        main_cp = {1'b0, hs_reg, u[9:0]} + PLANE1;
                    end
                    else
                    begin
                        // Unpaired high surrogate; the unit is taken on its own.
                        pre   = 1'b1;
                        fresh = 1'b1;
                    end
                end
                else
                begin
                    fresh = 1'b1;
                end

                if (fresh)
                begin
                    if ((u >= HIGH_FIRST) && (u <= HIGH_LAST))
                    begin
                        if (last)
                        begin
                            main_v  = 1'b1;
                            main_cp = REPL_CP;
                        end
                        else
                        begin
                            hs_next   = u[9:0];
                            pend_next = 1'b1;
                        end
                    end
                    else if ((u >= LOW_FIRST) && (u <= LOW_LAST))
                    begin
                        main_v  = 1'b1;
                        main_cp = REPL_CP;
                    end
                    else
                    begin
                        main_v  = 1'b1;
                        main_cp = {5'd0, u};
                    end
                end
            end

            default:
            begin
                main_v  = 1'b1;
                main_cp = cp_invalid(w) ? REPL_CP : w[20:0];
            end
        endcase

        if (last)
        begin
            acc_next  = '0;
            exp_next  = '0;
            rec_next  = '0;
            hs_next   = '0;
            pend_next = 1'b0;
        end
    end

    assign dec.cp0 = pre ? REPL_CP : main_cp;
    assign dec.cp1 = main_cp;
    assign dec.ncp = {1'b0, pre} + {1'b0, main_v};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            exp_reg  <= '0;
            rec_reg  <= '0;
            hs_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else if (src_clear)
        begin
            acc_reg  <= '0;
            exp_reg  <= '0;
            rec_reg  <= '0;
            hs_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            exp_reg  <= exp_next;
            rec_reg  <= rec_next;
            hs_reg   <= hs_next;
            pend_reg <= pend_next;
        end
    end

    `UCT_ASSERT_IMP(a_one_kind_open, clk, rst_n, 1'b1, !(pend_reg && (exp_reg != 3'd0)), "UTF-8 sequence and surrogate open together")
    `UCT_ASSERT_IMP(a_rec_in_range, clk, rst_n, exp_reg != 3'd0, (rec_reg != 3'd0) && (rec_reg < exp_reg), "UTF-8 byte count out of range")
    `UCT_ASSERT_NXT(a_src_clear, clk, rst_n, src_clear, (exp_reg == 3'd0) && !pend_reg, "decode state survives source format write")

endmodule

[hdl/uct_emitter.sv]
//------------------------------------------------------------------------------
// Unicode transcoder emitter
// Result register for the code points of one source unit; encodes them in
// the target format and hands out one destination unit per transaction.
//------------------------------------------------------------------------------
`include "unicode_transcoder_defines.svh"

module uct_emitter
    import uct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  dec_out_t    dec,
    input  fmt_t        tgt_fmt,
    input  logic        swap,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic        vld_reg, vld_next;
    logic [20:0] cp0_reg, cp0_next;
    logic [20:0] cp1_reg, cp1_next;
    logic [1:0]  ncp_reg, ncp_next;
    logic        sel_reg, sel_next;
    logic [1:0]  idx_reg, idx_next;

    logic [20:0] cur_cp;
    logic [2:0]  cur_n;
    logic        last_cp;
    logic        cp_done;
    logic        final_unit;
    logic        take;

    function automatic logic [2:0] unit_count(input logic [20:0] cp, input fmt_t fmt);
        logic [2:0] n;
        case (fmt)
            FMT_UTF8:  n = utf8_len(cp);
            FMT_UTF16: n = (cp >= PLANE1) ? 3'd2 : 3'd1;
            default:   n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] encode_unit(input logic [20:0] cp, input fmt_t fmt,
                                                input logic sw, input logic [1:0] k);
        logic [2:0]  n;
        logic [1:0]  j;
        logic [5:0]  chunk;
        logic [7:0]  byte_out;
        logic [19:0] v;
        logic [20:0] vfull;
        logic [15:0] half;
        logic [31:0] res;
        n        = utf8_len(cp);
        j        = n[1:0] - 2'd1 - k;
        vfull    = cp - PLANE1;
        v        = vfull[19:0];
        chunk    = '0;
        byte_out = '0;
        half     = '0;
        res      = '0;
        case (fmt)
            FMT_UTF8:
            begin
                case (j)
                    2'd0:    chunk = cp[5:0];
                    2'd1:    chunk = cp[11:6];
                    default: chunk = cp[17:12];
                endcase
                if (n == 3'd1)
                    byte_out = cp[7:0];
                else if (k == 2'd0)
                begin
                    case (n)
                        3'd2:    byte_out = {3'b110, cp[10:6]};
                        3'd3:    byte_out = {4'b1110, cp[15:12]};
                        default: byte_out = {5'b11110, cp[20:18]};
                    endcase
                end
                else
                    byte_out = {2'b10, chunk};
                res = {24'd0, byte_out};
            end
            FMT_UTF16:
            begin
                if (cp < PLANE1)
                    half = cp[15:0];
                else if (k == 2'd0)
                    half = {6'b110110, v[19:10]};
                else
                    half = {6'b110111, v[9:0]};
                res = {16'd0, sw ? swap16(half) : half};
            end
            default:
            begin
                res = sw ? swap32({11'd0, cp}) : {11'd0, cp};
            end
        endcase
        return res;
    endfunction

    assign cur_cp     = sel_reg ? cp1_reg : cp0_reg;
    assign cur_n      = unit_count(cur_cp, tgt_fmt);
    assign last_cp    = sel_reg || (ncp_reg == 2'd1);
    assign cp_done    = ({1'b0, idx_reg} == (cur_n - 3'd1));
    assign final_unit = last_cp && cp_done;
    assign take       = vld_reg && m_tready;
    assign free       = !vld_reg || (take && final_unit);

    assign m_tvalid = vld_reg;
    assign m_tdata  = encode_unit(cur_cp, tgt_fmt, swap, idx_reg);
    assign m_tlast  = final_unit;
    assign m_tuser  = (cur_cp == '0);

    always_comb
    begin
        vld_next = vld_reg;
        cp0_next = cp0_reg;
        cp1_next = cp1_reg;
        ncp_next = ncp_reg;
        sel_next = sel_reg;
        idx_next = idx_reg;
        if (take)
        begin
            if (final_unit)
                vld_next = 1'b0;
            else if (cp_done)
            begin
                sel_next = 1'b1;
                idx_next = '0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
        // A source unit that only extends a sequence brings nothing to load.
        if (load && (dec.ncp != 2'd0))
        begin
            vld_next = 1'b1;
            cp0_next = dec.cp0;
            cp1_next = dec.cp1;
            ncp_next = dec.ncp;
            sel_next = 1'b0;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            ncp_reg <= '0;
            sel_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            ncp_reg <= ncp_next;
            sel_reg <= sel_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp0_reg <= cp0_next;
        cp1_reg <= cp1_next;
    end

    `UCT_ASSERT_IMP(a_sel_ok, clk, rst_n, vld_reg, (ncp_reg != 2'd0) && (!sel_reg || (ncp_reg == 2'd2)), "code point select beyond loaded count")
    `UCT_ASSERT_IMP(a_idx_ok, clk, rst_n, vld_reg, ({1'b0, idx_reg} < cur_n), "unit index beyond encoded length")
    `UCT_ASSERT_NXT(a_drain, clk, rst_n, take && final_unit && !(load && (dec.ncp != 2'd0)), !vld_reg, "result stays valid after its last unit")

endmodule

[hdl/unicode_transcoder.sv]
// A source unit accepted into the input register is loaded into the result register
// once the emitter is free, and its first destination unit is then offered from there.
// Throughput: one source unit per cycle while each yields at most one unit and the
// output is not back-pressured; a unit that yields k destination units holds the
// output register for k transactions. Reset: clears the decode state and valid
// flags; source UTF-8, target UTF-16, no byte swap.
//------------------------------------------------------------------------------
// Unicode transcoder top level
// Input register, configuration registers, decoder and emitter between a
// streaming slave port and a streaming master port.
//------------------------------------------------------------------------------
module unicode_transcoder
    import uct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // source units
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] in_unit
    input  logic        s_tlast,
    // destination units
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] out_unit
    output logic        m_tlast,
    output logic        m_tuser      // [0] out_terminator
);

    localparam logic [1:0] REG_SRC  = 2'd0;
    localparam logic [1:0] REG_TGT  = 2'd1;
    localparam logic [1:0] REG_SWAP = 2'd2;

    fmt_t        src_fmt_reg, src_fmt_next;
    fmt_t        tgt_fmt_reg, tgt_fmt_next;
    logic        swap_reg, swap_next;
    logic        in_vld_reg, in_vld_next;
    logic [31:0] in_unit_reg, in_unit_next;
    logic        in_last_reg, in_last_next;

    logic        cfg_wr;
    logic        src_clear;
    fmt_t        wr_fmt;
    logic        emit_free;
    logic        advance;
    dec_out_t    dec;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign src_clear = cfg_wr && (paddr[3:2] == REG_SRC);

    // Format code three is taken as UTF-32.
    always_comb
    begin
        case (pwdata[1:0])
            FMT_UTF8:  wr_fmt = FMT_UTF8;
            FMT_UTF16: wr_fmt = FMT_UTF16;
            default:   wr_fmt = FMT_UTF32;
        endcase
    end

    always_comb
    begin
        src_fmt_next = src_fmt_reg;
        tgt_fmt_next = tgt_fmt_reg;
        swap_next    = swap_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SRC:  src_fmt_next = wr_fmt;
                REG_TGT:  tgt_fmt_next = wr_fmt;
                REG_SWAP: swap_next    = pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SRC:  prdata = {30'd0, src_fmt_reg};
            REG_TGT:  prdata = {30'd0, tgt_fmt_reg};
            REG_SWAP: prdata = {31'd0, swap_reg};
            default:  prdata = '0;
        endcase
    end

    // The input register moves on whenever the emitter can take a new result,
    // so a new transaction is accepted while the previous result still waits.
    assign advance  = in_vld_reg && emit_free;
    assign s_tready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_unit_next = in_unit_reg;
        in_last_next = in_last_reg;
        if (advance)
            in_vld_next = 1'b0;
        if (s_tvalid && s_tready)
        begin
            in_vld_next  = 1'b1;
            in_unit_next = s_tdata;
            in_last_next = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= FMT_UTF8;
            tgt_fmt_reg <= FMT_UTF16;
            swap_reg    <= 1'b0;
            in_vld_reg  <= 1'b0;
        end
        else
        begin
            src_fmt_reg <= src_fmt_next;
            tgt_fmt_reg <= tgt_fmt_next;
            swap_reg    <= swap_next;
            in_vld_reg  <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_unit_reg <= in_unit_next;
        in_last_reg <= in_last_next;
    end

    uct_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .src_clear (src_clear),
        .src_fmt   (src_fmt_reg),
        .swap      (swap_reg),
        .unit      (in_unit_reg),
        .last      (in_last_reg),
        .dec       (dec)
    );

    uct_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .dec      (dec),
        .tgt_fmt  (tgt_fmt_reg),
        .swap     (swap_reg),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Unicode transcoder testbench
// Feeds UTF-8, UTF-16 and UTF-32 source units through every pairing of source
// and target format, with and without byte swapping, and checks each
// destination unit against a transaction-level model of the decoder and
// encoder. Directed malformed sequences come first, then random text with
// broken sequences mixed in, under changing back-pressure on both sides.
//------------------------------------------------------------------------------

import uct_pkg::*;

localparam int          REG_SOURCE_FORMAT = 0;
localparam int          REG_TARGET_FORMAT = 1;
localparam int          REG_SWAP_BYTES    = 2;
localparam bit [31:0]   REPLACEMENT       = 32'h0000FFFD;
localparam int          MAX_UNITS_PER_IN  = 6;

typedef struct {
    logic [31:0] unit;
    logic        term;
    logic        run_end;
} dest_unit_t;

function automatic bit [31:0] byte_rev16(input bit [31:0] v);
    return {16'd0, v[7:0], v[15:8]};
endfunction

function automatic bit [31:0] byte_rev32(input bit [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
endfunction

// Number of UTF-8 bytes that a code point needs in its shortest form.
function automatic int enc_len(input bit [31:0] cp);
    if (cp < 32'h80)
        return 1;
    else if (cp < 32'h800)
        return 2;
    else if (cp < 32'h10000)
        return 3;
    return 4;
endfunction

class transcode_scoreboard;
    fmt_t       src_fmt;
    fmt_t       dst_fmt;
    bit         swap_en;
    bit [20:0]  acc;
    bit [2:0]   seq_len;
    bit [2:0]   seq_got;
    bit [15:0]  high_surr;
    bit         surr_open;
    dest_unit_t step_units[$];
    dest_unit_t expected_units[$];
    int         errors;

    function new();
        src_fmt = FMT_UTF8;
        dst_fmt = FMT_UTF16;
        swap_en = 1'b0;
        errors  = 0;
        clear_decode();
    endfunction

    function void clear_decode();
        acc       = '0;
        seq_len   = '0;
        seq_got   = '0;
        high_surr = '0;
        surr_open = 1'b0;
    endfunction

    function fmt_t to_fmt(input bit [1:0] code);
        return (code == 2'd3) ? FMT_UTF32 : fmt_t'(code);
    endfunction

    function void set_reg(input int idx, input logic [31:0] value);
        case (idx)
            REG_SOURCE_FORMAT:
            begin
                src_fmt = to_fmt(value[1:0]);
                clear_decode();
            end
            REG_TARGET_FORMAT: dst_fmt = to_fmt(value[1:0]);
            REG_SWAP_BYTES:    swap_en = value[0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_units.size();
    endfunction

    function void stage(input bit [31:0] unit, input bit term);
        dest_unit_t d;
        if (step_units.size() >= MAX_UNITS_PER_IN)
            return;
        d.unit    = unit;
        d.term    = term;
        d.run_end = 1'b0;
        step_units.push_back(d);
    endfunction

    function bit bad_cp(input bit [31:0] cp);
        return (cp >= 32'hD800 && cp <= 32'hDFFF) || cp > 32'h10FFFF;
    endfunction

    function void emit_cp(input bit [31:0] cp);
        bit [31:0] v;
        bit [31:0] hi;
        bit [31:0] lo;
        if (cp == 0)
        begin
            stage(32'd0, 1'b1);
            clear_decode();
            return;
        end
        case (dst_fmt)
            FMT_UTF8:
            begin
                case (enc_len(cp))
                    1: stage(cp, 1'b0);
                    2:
                    begin
                        stage(32'hC0 | (cp >> 6), 1'b0);
                        stage(32'h80 | (cp & 32'h3F), 1'b0);
                    end
                    3:
                    begin
                        stage(32'hE0 | (cp >> 12), 1'b0);
                        stage(32'h80 | ((cp >> 6) & 32'h3F), 1'b0);
                        stage(32'h80 | (cp & 32'h3F), 1'b0);
                    end
                    default:
                    begin
                        stage(32'hF0 | ((cp >> 18) & 32'h7), 1'b0);
                        stage(32'h80 | ((cp >> 12) & 32'h3F), 1'b0);
                        stage(32'h80 | ((cp >> 6) & 32'h3F), 1'b0);
                        stage(32'h80 | (cp & 32'h3F), 1'b0);
                    end
                endcase
            end
            FMT_UTF16:
            begin
                if (cp < 32'h10000)
                    stage(swap_en ? byte_rev16(cp) : cp, 1'b0);
                else
                begin
                    v  = cp - 32'h10000;
                    hi = 32'hD800 | ((v >> 10) & 32'h3FF);
                    lo = 32'hDC00 | (v & 32'h3FF);
                    stage(swap_en ? byte_rev16(hi) : hi, 1'b0);
                    stage(swap_en ? byte_rev16(lo) : lo, 1'b0);
                end
            end
            default: stage(swap_en ? byte_rev32(cp) : cp, 1'b0);
        endcase
    endfunction

    function void utf8_lead(input bit [7:0] b, input bit is_last);
        bit [2:0] n;
        if (b < 8'h80)
        begin
            emit_cp({24'd0, b});
            return;
        end
        if (b < 8'hC0 || b >= 8'hF8)
        begin
            emit_cp(REPLACEMENT);
            return;
        end
        n       = (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : 3'd4;
        acc     = {13'd0, b & (8'h7F >> n)};
        seq_len = n;
        seq_got = 3'd1;
        if (is_last)
        begin
            clear_decode();
            emit_cp(REPLACEMENT);
        end
    endfunction

    function void utf8_byte(input bit [7:0] b, input bit is_last);
        bit [31:0] cp;
        int        n;
        if (seq_len != 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                acc     = {acc[14:0], b[5:0]};
                seq_got = seq_got + 3'd1;
                if (seq_got >= seq_len)
                begin
                    cp = {11'd0, acc};
                    n  = seq_len;
                    clear_decode();
                    emit_cp((bad_cp(cp) || enc_len(cp) != n) ? REPLACEMENT : cp);
                end
                else if (is_last)
                begin
                    clear_decode();
                    emit_cp(REPLACEMENT);
                end
                return;
            end
            // A broken sequence is replaced, and the byte then starts afresh.
            clear_decode();
            emit_cp(REPLACEMENT);
        end
        utf8_lead(b, is_last);
    endfunction

    function void utf16_unit(input bit [15:0] u, input bit is_last);
        bit [31:0] cp;
        if (surr_open)
        begin
            if (u >= 16'hDC00 && u <= 16'hDFFF)
            begin
                cp = {12'd0, high_surr[9:0], u[9:0]} + 32'h10000;
                clear_decode();
                emit_cp(cp);
                return;
            end
            clear_decode();
            emit_cp(REPLACEMENT);
        end
        if (u >= 16'hD800 && u <= 16'hDBFF)
        begin
            if (is_last)
            begin
                emit_cp(REPLACEMENT);
                return;
            end
            high_surr = u;
            surr_open = 1'b1;
        end
        else if (u >= 16'hDC00 && u <= 16'hDFFF)
            emit_cp(REPLACEMENT);
        else
            emit_cp({16'd0, u});
    endfunction

    // Works out the destination units caused by one accepted source unit.
    function void transcode(input logic [31:0] unit, input logic is_last);
        bit [31:0] cp;
        step_units.delete();
        case (src_fmt)
            FMT_UTF8:  utf8_byte(unit[7:0], is_last);
            FMT_UTF16: utf16_unit(swap_en ? {unit[7:0], unit[15:8]} : unit[15:0], is_last);
            default:
            begin
                cp = swap_en ? byte_rev32(unit) : unit;
                emit_cp(bad_cp(cp) ? REPLACEMENT : cp);
            end
        endcase
        if (is_last)
            clear_decode();
        if (step_units.size() > 0)
            step_units[step_units.size() - 1].run_end = 1'b1;
        foreach (step_units[i])
            expected_units.push_back(step_units[i]);
    endfunction

    function void check_unit(input logic [31:0] unit, input logic term, input logic run_end);
        dest_unit_t e;
        if (expected_units.size() == 0)
        begin
            $display("%0t: unexpected destination unit %h (terminator %b, run end %b)",
                     $time, unit, term, run_end);
            errors++;
            return;
        end
        e = expected_units.pop_front();
        if (unit !== e.unit)
        begin
            $display("%0t: out_unit expected %h, actual %h", $time, e.unit, unit);
            errors++;
        end
        if (term !== e.term)
        begin
            $display("%0t: out_terminator expected %b, actual %b", $time, e.term, term);
            errors++;
        end
        if (run_end !== e.run_end)
        begin
            $display("%0t: out_run_end expected %b, actual %b", $time, e.run_end, run_end);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int NUM_PHASES    = 12;
    localparam int UNITS_PER_PHASE = 28;

    // Register settings per random phase: source, target, swap.
    localparam logic [1:0] PH_SRC  [NUM_PHASES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
                                                    2'd2, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] PH_DST  [NUM_PHASES] = '{2'd0, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
                                                    2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd1};
    localparam logic       PH_SWAP [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                                    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    // Bit 32 carries in_last.
    localparam logic [32:0] OPENING [21] = '{
        33'h0ABCDEF41,
        33'h0C3, 33'h0A9,
        33'h0F0, 33'h09F, 33'h098, 33'h080,
        33'h0C0, 33'h080,
        33'h0ED, 33'h0A0, 33'h080,
        33'h0F4, 33'h090, 33'h080, 33'h080,
        33'h080,
        33'h0FF,
        33'h0E2, 33'h041,
        33'h1E2
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;      // [31:0] in_unit
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] out_unit
    logic        m_tlast;
    logic        m_tuser;            // [0] out_terminator

    transcode_scoreboard sb = new();

    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int unsigned cycle_count  = 0;
    logic [31:0] burst_unit[$];
    logic        burst_last[$];

    unicode_transcoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_unit(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_unit(input logic [31:0] unit, input logic is_last);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.transcode(unit, is_last);
    endtask

    // The task always waits on the clock before it returns, so the next drive lands in a later time step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Units that cause no result may still be in the pipeline once the queue
    // is empty, so the task waits on the clock again before the registers change.
    task automatic settle();
        wait_drained();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [1:0] src, input logic [1:0] dst,
                                input logic swp);
        logic [31:0] vals [3];
        int          i;
        vals[REG_SOURCE_FORMAT] = {30'd0, src};
        vals[REG_TARGET_FORMAT] = {30'd0, dst};
        vals[REG_SWAP_BYTES]    = {31'd0, swp};
        for (i = REG_SOURCE_FORMAT; i <= REG_SWAP_BYTES; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 4'(4 * i);
            pwdata  <= vals[i];
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            sb.set_reg(i, vals[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Queues a unit, sometimes with junk above the unit width and now and then
    // marked as the end of the source buffer.
    function automatic void add_unit(input bit [31:0] v, input int width);
        bit [31:0] junk;
        junk = $urandom;
        if (width == 8 && $urandom_range(0, 3) == 0)
            v = {junk[31:8], v[7:0]};
        else if (width == 16 && $urandom_range(0, 3) == 0)
            v = {junk[31:16], v[15:0]};
        burst_unit.push_back(v);
        burst_last.push_back($urandom_range(0, 39) == 0);
    endfunction

    // Encodes cp in n UTF-8 bytes (overlong when n exceeds the shortest form),
    // leaving out the final drop bytes.
    function automatic void add_utf8(input bit [31:0] cp, input int n, input int drop);
        bit [31:0] b [4];
        int        i;
        case (n)
            1: b[0] = cp & 32'h7F;
            2:
            begin
                b[0] = 32'hC0 | ((cp >> 6) & 32'h1F);
                b[1] = 32'h80 | (cp & 32'h3F);
            end
            3:
            begin
                b[0] = 32'hE0 | ((cp >> 12) & 32'hF);
                b[1] = 32'h80 | ((cp >> 6) & 32'h3F);
                b[2] = 32'h80 | (cp & 32'h3F);
            end
            default:
            begin
                b[0] = 32'hF0 | ((cp >> 18) & 32'h7);
                b[1] = 32'h80 | ((cp >> 12) & 32'h3F);
                b[2] = 32'h80 | ((cp >> 6) & 32'h3F);
                b[3] = 32'h80 | (cp & 32'h3F);
            end
        endcase
        for (i = 0; i < n - drop; i++)
            add_unit(b[i], 8);
    endfunction

    function automatic void add16(input bit [31:0] v, input bit sw);
        add_unit(sw ? byte_rev16(v) : {16'd0, v[15:0]}, 16);
    endfunction

    function automatic bit [31:0] rand_cp();
        bit [31:0] boundary [10] = '{32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF,
                                     32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'hFFFD};
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(1, 32'h7F);
            3:       return $urandom_range(32'h80, 32'h7FF);
            4, 5:    return $urandom_range(32'h800, 32'hFFFF);
            6, 7:    return $urandom_range(32'h10000, 32'h10FFFF);
            8:       return boundary[$urandom_range(0, 9)];
            default: return 32'd0;
        endcase
    endfunction

    // One character's worth of source units: mostly well formed, the rest
    // broken, overlong, out of range or plain noise.
    function automatic void gen_chunk(input fmt_t src, input bit sw);
        bit [31:0] c;
        bit [31:0] v;
        int        r;
        int        n;
        case (src)
            FMT_UTF8:
            begin
                r = $urandom_range(0, 19);
                case (r)
                    14: add_unit($urandom_range(0, 255), 8);
                    15:
                    begin
                        c = $urandom_range(32'h80, 32'h10FFFF);
                        add_utf8(c, enc_len(c), 1);
                    end
                    16:
                    begin
                        n = $urandom_range(2, 4);
                        c = $urandom_range(0, (n == 2) ? 32'h7F : (n == 3) ? 32'h7FF : 32'hFFFF);
                        add_utf8(c, n, 0);
                    end
                    17: add_utf8($urandom_range(32'hD800, 32'hDFFF), 3, 0);
                    18: add_utf8($urandom_range(32'h110000, 32'h1FFFFF), 4, 0);
                    19: add_unit($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                                      : $urandom_range(8'hF8, 8'hFF), 8);
                    default:
                    begin
                        c = rand_cp();
                        add_utf8(c, enc_len(c), 0);
                    end
                endcase
            end
            FMT_UTF16:
            begin
                r = $urandom_range(0, 15);
                case (r)
                    11: add16($urandom_range(32'hD800, 32'hDBFF), sw);
                    12: add16($urandom_range(32'hDC00, 32'hDFFF), sw);
                    13: add16($urandom_range(0, 32'hFFFF), sw);
                    14:
                    begin
                        add16($urandom_range(32'hD800, 32'hDBFF), sw);
                        burst_last[burst_last.size() - 1] = 1'b1;
                    end
                    15:
                    begin
                        add16($urandom_range(32'hD800, 32'hDBFF), sw);
                        add16($urandom_range(32'hD800, 32'hDBFF), sw);
                    end
                    default:
                    begin
                        c = rand_cp();
                        if (c < 32'h10000)
                            add16(c, sw);
                        else
                        begin
                            v = c - 32'h10000;
                            add16(32'hD800 | (v >> 10), sw);
                            add16(32'hDC00 | (v & 32'h3FF), sw);
                        end
                    end
                endcase
            end
            default:
            begin
                r = $urandom_range(0, 9);
                case (r)
                    6:       c = $urandom;
                    7:       c = $urandom_range(32'hD800, 32'hDFFF);
                    8:       c = $urandom_range(32'h110000, 32'h11FFFF);
                    9:       c = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h80000000;
                    default: c = rand_cp();
                endcase
                add_unit(sw ? byte_rev32(c) : c, 32);
            end
        endcase
        if ($urandom_range(0, 11) == 0)
            burst_last[burst_last.size() - 1] = 1'b1;
    endfunction

    initial
    begin
        int   ph;
        int   sent;
        bit   paused;
        fmt_t src;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n        <= 1'b1;
        snd_idle_pct  = 21;
        rcv_idle_pct <= 52;
        @(posedge clk);

        // Directed malformed and boundary sequences under the reset settings.
        foreach (OPENING[i])
            send_unit(OPENING[i][31:0], OPENING[i][32]);
        // A source format write must discard an open sequence.
        send_unit(32'hE2, 1'b0);
        settle();
        write_config(FMT_UTF8, FMT_UTF16, 1'b0);
        send_unit(32'h00, 1'b0);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 4)
            begin
                snd_idle_pct  = 52;
                rcv_idle_pct <= 21;
            end
            else if (ph == 8)
            begin
                snd_idle_pct  = 0;
                rcv_idle_pct <= 0;
            end
            settle();
            write_config(PH_SRC[ph], PH_DST[ph], PH_SWAP[ph]);
            src  = sb.to_fmt(PH_SRC[ph]);
            sent = 0;
            while (sent < UNITS_PER_PHASE)
            begin
                gen_chunk(src, PH_SWAP[ph]);
                while (burst_unit.size() > 0)
                begin
                    send_unit(burst_unit.pop_front(), burst_last.pop_front());
                    sent++;
                end
                // Let the output side run completely dry once mid-stream.
                if (ph == 5 && !paused && sent >= UNITS_PER_PHASE / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
